@@ rtl/ltcmv_pkg.sv @@
// Shared constants, types and the sequencer program for the lower triangular
// complex matrix-vector core. No dependencies; used by the top-level module.
package ltcmv_pkg;

	localparam int DEGREE_CAP_DEF = 9;
	localparam int DEG_W          = 4;
	localparam logic [DEG_W-1:0] DEG_RESET = 4'd9;
	localparam int IDX_W          = 7;
	localparam int VAL_W          = 32;
	localparam int FRAC_W         = 23;
	// Up to 128 terms of a 65-bit complex partial sum fit in 72 bits.
	localparam int ACC_W          = 72;
	localparam int S_DATA_W       = 80;
	localparam int M_DATA_W       = 72;

	localparam logic [ACC_W-1:0] RND_HALF =
		{{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

	typedef logic [2:0] step_t;

	localparam step_t STEP_FETCH = 3'd0;
	localparam step_t STEP_MAC   = 3'd1;
	localparam step_t STEP_DRAIN = 3'd2;
	localparam step_t STEP_ROUND = 3'd3;
	localparam step_t STEP_SAT   = 3'd4;
	localparam step_t STEP_EMIT  = 3'd5;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_DISPATCH,
		COND_LOOP,
		COND_DRAIN,
		COND_EMIT
	} cond_t;

	typedef struct packed {
		logic  ready;
		logic  issue;
		logic  rnd;
		logic  sat;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic             sat;
		logic [VAL_W-1:0] val;
	} round_sat_t;

	// Control store: one word per sequencer step.
	function automatic ucode_t ucode_rom(step_t step);
		ucode_t w;
		w.ready  = 1'b0;
		w.issue  = 1'b0;
		w.rnd    = 1'b0;
		w.sat    = 1'b0;
		w.cond   = COND_NEXT;
		w.target = STEP_FETCH;
		unique case (step)
			STEP_FETCH: begin
				w.ready  = 1'b1;
				w.cond   = COND_DISPATCH;
				w.target = STEP_EMIT;
			end
			STEP_MAC: begin
				w.issue = 1'b1;
				w.cond  = COND_LOOP;
			end
			STEP_DRAIN: begin
				w.cond = COND_DRAIN;
			end
			STEP_ROUND: begin
				w.rnd = 1'b1;
			end
			STEP_SAT: begin
				w.sat = 1'b1;
			end
			STEP_EMIT: begin
				w.cond   = COND_EMIT;
				w.target = STEP_FETCH;
			end
			default: begin
				w.cond   = COND_JUMP;
				w.target = STEP_FETCH;
			end
		endcase
		return w;
	endfunction

	// Vector length (d+1)^2 with the degree clamped to the build maximum.
	function automatic int vec_len(logic [DEG_W-1:0] deg, int deg_cap);
		int d;
		d = (int'(deg) > deg_cap) ? deg_cap : int'(deg);
		return (d + 1) * (d + 1);
	endfunction

	// Takes the rounded accumulator and clips the Q8.23 result to 32 bits.
	function automatic round_sat_t round_sat(logic [ACC_W-1:0] t);
		round_sat_t r;
		logic [ACC_W-FRAC_W-VAL_W:0] hi;
		hi = t[ACC_W-1:FRAC_W+VAL_W-1];
		if (hi == '0 || hi == '1) begin
			r.sat = 1'b0;
			r.val = t[FRAC_W+VAL_W-1:FRAC_W];
		end else begin
			r.sat = 1'b1;
			r.val = t[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

@@ rtl/lower_triangular_complex_matvec_core.sv @@
// Top level of the lower triangular complex matrix-vector core: microcoded
// sequencer, matrix and vector RAMs, complex MAC pipeline, output register.
// Depends on ltcmv_pkg.
//
// Usage: the slave stream carries one item per handshake; tuser[0] selects a
// matrix entry write (0) or a vector element (1). A matrix write gives no
// result. Vector element c must arrive in ascending order and returns b[c] =
// sum over k <= c of A[c][k] * x[k] on the master stream, rounded to Q8.23
// and saturated. Bad indexes return a flagged zero result. The block takes
// no new item until an element's result has moved into the output register.
// Each element runs through the single complex MAC that walks the matrix
// row, one RAM read per cycle, then the pipeline drain, rounding and
// saturation. A result waits in the output register while the receiver
// stalls; matrix writes are still taken meanwhile, and a later result holds
// the sequencer in its emit step until the register frees.
// Reset sets degree_limit to 9 and the expected element to 0; the RAMs are
// not cleared and must be written before use. The configuration write sets
// degree_limit and restarts the element order at 0.
module lower_triangular_complex_matvec_core #(
	parameter int DEGREE_CAP = ltcmv_pkg::DEGREE_CAP_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [ltcmv_pkg::DEG_W-1:0]      cfg_wdata,    // degree_limit
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// row_index[6:0], col_index[13:7], value_re[45:14], value_im[77:46], zero
	input  logic [ltcmv_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic [0:0]                       s_tuser,      // func
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_index[6:0], out_re[38:7], out_im[70:39], zero
	output logic [ltcmv_pkg::M_DATA_W-1:0]   m_tdata,
	output logic [1:0]                       m_tuser       // saturated, bad_index
);

	localparam int IDX_W = ltcmv_pkg::IDX_W;
	localparam int VAL_W = ltcmv_pkg::VAL_W;
	localparam int ACC_W = ltcmv_pkg::ACC_W;
	localparam int DIM   = (DEGREE_CAP + 1) * (DEGREE_CAP + 1);
	localparam int LEN_W = $clog2(DIM + 1);
	localparam int CMP_W = (LEN_W > IDX_W + 1) ? LEN_W : IDX_W + 1;
	localparam int MA_W  = (DIM * DIM > 1) ? $clog2(DIM * DIM) : 1;
	localparam int VA_W  = (DIM > 1) ? $clog2(DIM) : 1;

	ltcmv_pkg::ucode_t cw;
	ltcmv_pkg::step_t  pc_q, pc_d;

	logic [IDX_W-1:0] in_row, in_col;
	logic [VAL_W-1:0] in_re, in_im;
	logic             in_func;
	logic             accept, mat_ok, elem_ok, out_free, last_k, pipe_busy;
	logic [IDX_W-1:0] next_d;
	logic [MA_W-1:0]  waddr;

	logic [CMP_W-1:0] len_q;
	logic [IDX_W-1:0] next_q;
	logic [IDX_W-1:0] col_q, k_q;
	logic [MA_W-1:0]  maddr_q;

	logic [2*VAL_W-1:0] mat_mem [DIM*DIM];
	logic [2*VAL_W-1:0] vec_mem [DIM];

	logic [2*VAL_W-1:0] a_s1, x_s1;
	logic               v_s1, v_s2, v_s3;
	logic signed [VAL_W-1:0]   a_re, a_im, x_re, x_im;
	logic signed [2*VAL_W-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [2*VAL_W:0]   sr_s3, si_s3;
	logic signed [ACC_W-1:0]   acc_re_q, acc_im_q;
	logic [ACC_W-1:0]          rnd_re_q, rnd_im_q;
	ltcmv_pkg::round_sat_t     rs_re, rs_im;

	logic [IDX_W-1:0] res_idx_q, out_idx_q;
	logic [VAL_W-1:0] res_re_q, res_im_q, out_re_q, out_im_q;
	logic             res_sat_q, res_bad_q, out_sat_q, out_bad_q, out_valid_q;

	assign in_func = s_tuser[0];
	assign in_row  = s_tdata[IDX_W-1:0];
	assign in_col  = s_tdata[2*IDX_W-1:IDX_W];
	assign in_re   = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
	assign in_im   = s_tdata[2*IDX_W+2*VAL_W-1:2*IDX_W+VAL_W];

	assign cw       = ltcmv_pkg::ucode_rom(pc_q);
	assign s_tready = cw.ready;
	assign accept   = s_tvalid & s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign last_k   = (k_q == col_q);
	assign pipe_busy = v_s1 | v_s2 | v_s3;

	assign mat_ok  = !in_func && (CMP_W'(in_row) < len_q) && (CMP_W'(in_col) < len_q);
	assign elem_ok = in_func && (CMP_W'(in_col) < len_q) && (in_col == next_q);
	assign next_d  = ((CMP_W'(in_col) + CMP_W'(1)) >= len_q) ? '0 : in_col + IDX_W'(1);
	assign waddr   = MA_W'(int'(in_row) * DIM + int'(in_col));

	// Step sequencing: each control word names a jump condition and target.
	always_comb begin
		pc_d = pc_q;
		unique case (cw.cond)
			ltcmv_pkg::COND_NEXT: pc_d = pc_q + 3'd1;
			ltcmv_pkg::COND_JUMP: pc_d = cw.target;
			ltcmv_pkg::COND_DISPATCH: begin
				if (accept) begin
					if (elem_ok) begin
						pc_d = pc_q + 3'd1;
					end else if (!mat_ok) begin
						pc_d = cw.target;
					end
				end
			end
			ltcmv_pkg::COND_LOOP: begin
				if (last_k) begin
					pc_d = pc_q + 3'd1;
				end
			end
			ltcmv_pkg::COND_DRAIN: begin
				if (!pipe_busy) begin
					pc_d = pc_q + 3'd1;
				end
			end
			ltcmv_pkg::COND_EMIT: begin
				if (out_free) begin
					pc_d = cw.target;
				end
			end
			default: pc_d = ltcmv_pkg::STEP_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= ltcmv_pkg::STEP_FETCH;
			len_q       <= CMP_W'(ltcmv_pkg::vec_len(ltcmv_pkg::DEG_RESET, DEGREE_CAP));
			next_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (cfg_wen) begin
				len_q  <= CMP_W'(ltcmv_pkg::vec_len(cfg_wdata, DEGREE_CAP));
				next_q <= '0;
			end else if (accept && elem_ok) begin
				next_q <= next_d;
			end
			v_s1 <= cw.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cw.cond == ltcmv_pkg::COND_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Matrix and vector stores with registered reads.
	always_ff @(posedge clk) begin
		if (accept && mat_ok) begin
			mat_mem[waddr] <= {in_im, in_re};
		end
		a_s1 <= mat_mem[maddr_q];
	end

	always_ff @(posedge clk) begin
		if (accept && elem_ok) begin
			vec_mem[VA_W'(in_col)] <= {in_im, in_re};
		end
		x_s1 <= vec_mem[VA_W'(k_q)];
	end

	assign a_re = a_s1[VAL_W-1:0];
	assign a_im = a_s1[2*VAL_W-1:VAL_W];
	assign x_re = x_s1[VAL_W-1:0];
	assign x_im = x_s1[2*VAL_W-1:VAL_W];

	assign rs_re = ltcmv_pkg::round_sat(rnd_re_q);
	assign rs_im = ltcmv_pkg::round_sat(rnd_im_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q     <= in_col;
			k_q       <= '0;
			maddr_q   <= MA_W'(int'(in_col) * DIM);
			res_idx_q <= in_col;
			res_re_q  <= '0;
			res_im_q  <= '0;
			res_sat_q <= 1'b0;
			res_bad_q <= 1'b1;
		end else if (cw.issue && !last_k) begin
			k_q     <= k_q + IDX_W'(1);
			maddr_q <= maddr_q + MA_W'(1);
		end

		p_rr_s2 <= a_re * x_re;
		p_ii_s2 <= a_im * x_im;
		p_ri_s2 <= a_re * x_im;
		p_ir_s2 <= a_im * x_re;
		sr_s3   <= (2*VAL_W+1)'(p_rr_s2) - (2*VAL_W+1)'(p_ii_s2);
		si_s3   <= (2*VAL_W+1)'(p_ri_s2) + (2*VAL_W+1)'(p_ir_s2);

		if (accept) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s3) begin
			acc_re_q <= acc_re_q + ACC_W'(sr_s3);
			acc_im_q <= acc_im_q + ACC_W'(si_s3);
		end

		if (cw.rnd) begin
			rnd_re_q <= acc_re_q + ltcmv_pkg::RND_HALF;
			rnd_im_q <= acc_im_q + ltcmv_pkg::RND_HALF;
		end

		if (cw.sat) begin
			res_re_q  <= rs_re.val;
			res_im_q  <= rs_im.val;
			res_sat_q <= rs_re.sat | rs_im.sat;
			res_bad_q <= 1'b0;
		end

		if (cw.cond == ltcmv_pkg::COND_EMIT && out_free) begin
			out_idx_q <= res_idx_q;
			out_re_q  <= res_re_q;
			out_im_q  <= res_im_q;
			out_sat_q <= res_sat_q;
			out_bad_q <= res_bad_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(ltcmv_pkg::M_DATA_W-IDX_W-2*VAL_W){1'b0}},
		out_im_q, out_re_q, out_idx_q};
	assign m_tuser  = {out_bad_q, out_sat_q};

endmodule

@@ verif/tb_lower_triangular_complex_matvec_core.sv @@
// Self-checking testbench for lower_triangular_complex_matvec_core: a queued stream
// driver, a result monitor and a bit-exact predictor of the complex row products.
// Depends on ltcmv_pkg and the core RTL only.
module tb_lower_triangular_complex_matvec_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEG_W         = ltcmv_pkg::DEG_W;
	localparam int DEGREE_CAP    = ltcmv_pkg::DEGREE_CAP_DEF;
	localparam int DIM           = (DEGREE_CAP + 1) * (DEGREE_CAP + 1);
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_CYCLES  = 120;
	localparam int ITEM_TARGET   = 1550;

	localparam logic FUNC_MATRIX = 1'b0;
	localparam logic FUNC_VECTOR = 1'b1;

	localparam logic [31:0] Q_MAX      = 32'h7fffffff;
	localparam logic [31:0] Q_MIN      = 32'h80000000;
	localparam logic [31:0] Q_HALF_LSB = 32'h00400000;
	localparam logic [31:0] Q_ONE_LSB  = 32'h00000001;
	localparam logic [31:0] Q_MINUS_1  = 32'hffffffff;

	typedef struct packed {
		logic        func;
		logic [6:0]  row;
		logic [6:0]  col;
		logic [31:0] re;
		logic [31:0] im;
	} mv_item_t;

	typedef struct packed {
		logic [6:0]  index;
		logic [31:0] re;
		logic [31:0] im;
		logic        sat;
		logic        bad;
	} b_result_t;

	logic                             clk;
	logic                             arst_n = 1'b0;
	logic                             cfg_wen = 1'b0;
	logic [DEG_W-1:0]                 cfg_wdata = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [ltcmv_pkg::S_DATA_W-1:0]   s_tdata = '0;
	logic [0:0]                       s_tuser = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [ltcmv_pkg::M_DATA_W-1:0]   m_tdata;
	logic [1:0]                       m_tuser;

	mv_item_t  item_backlog[$];
	b_result_t expected_b[$];
	mv_item_t  item_on_bus;
	int        error_count = 0;
	int        cycle_count = 0;
	int        queued_count = 0;

	// Predictor state.
	logic [63:0]      matrix_a [0:DIM*DIM-1];
	logic [63:0]      vector_x [0:DIM-1];
	logic [6:0]       next_col_due = '0;
	logic [DEG_W-1:0] deg_now = ltcmv_pkg::DEG_RESET;

	// Stimulus planning state, kept in step with what has been queued.
	bit               plan_written [0:DIM*DIM-1];
	int               plan_next = 0;
	logic [DEG_W-1:0] plan_deg = ltcmv_pkg::DEG_RESET;

	lower_triangular_complex_matvec_core #(
		.DEGREE_CAP(DEGREE_CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int vector_len(input logic [DEG_W-1:0] deg);
		int d;
		d = (int'(deg) > DEGREE_CAP) ? DEGREE_CAP : int'(deg);
		return (d + 1) * (d + 1);
	endfunction

	// Round half up from Q16.46 to Q8.23, then clip to 32 bits.
	function automatic logic [31:0] round_q823(input logic signed [79:0] acc, inout logic sat);
		logic signed [79:0] t;
		t = (acc + 80'sd4194304) >>> 23;
		if (t > 80'sd2147483647) begin
			sat = 1'b1;
			return Q_MAX;
		end
		if (t < -80'sd2147483648) begin
			sat = 1'b1;
			return Q_MIN;
		end
		return t[31:0];
	endfunction

	task automatic compute_b_element(input mv_item_t it);
		int                 m;
		int                 k;
		logic signed [79:0] acc_re, acc_im, a_re, a_im, x_re, x_im;
		logic               sat;
		b_result_t          r;
		m = vector_len(deg_now);
		r.index = it.col;
		r.re = '0;
		r.im = '0;
		r.sat = 1'b0;
		r.bad = 1'b1;
		if (it.func == FUNC_MATRIX) begin
			if (it.row < m && it.col < m)
				matrix_a[it.row * DIM + it.col] = {it.im, it.re};
			else
				expected_b.push_back(r);
		end else if (it.col < m && it.col == next_col_due) begin
			vector_x[it.col] = {it.im, it.re};
			acc_re = '0;
			acc_im = '0;
			for (k = 0; k <= it.col; k++) begin
				a_re = $signed(matrix_a[it.col * DIM + k][31:0]);
				a_im = $signed(matrix_a[it.col * DIM + k][63:32]);
				x_re = $signed(vector_x[k][31:0]);
				x_im = $signed(vector_x[k][63:32]);
				acc_re = acc_re + a_re * x_re - a_im * x_im;
				acc_im = acc_im + a_re * x_im + a_im * x_re;
			end
			sat = 1'b0;
			r.re = round_q823(acc_re, sat);
			r.im = round_q823(acc_im, sat);
			r.sat = sat;
			r.bad = 1'b0;
			next_col_due = (it.col + 1 >= m) ? 7'd0 : 7'(it.col + 1);
			expected_b.push_back(r);
		end else begin
			expected_b.push_back(r);
		end
	endtask

	// Mostly values near unity so that sums stay in range, with some wide
	// and extreme values to drive saturation.
	function automatic logic [31:0] rand_q823();
		logic [31:0] v;
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 7)
			v = 32'($urandom_range(33554431)) - 32'd16777216;
		else if (sel == 7)
			v = $urandom;
		else if (sel == 8)
			v = 32'($urandom_range(536870911)) - 32'd268435456;
		else begin
			case ($urandom_range(4))
				0: v = Q_MAX;
				1: v = Q_MIN;
				2: v = '0;
				3: v = Q_MINUS_1;
				default: v = Q_ONE_LSB;
			endcase
		end
		return v;
	endfunction

	function automatic void queue_item(input logic func, input int row, input int col,
			input logic [31:0] re, input logic [31:0] im);
		int       m;
		mv_item_t it;
		m = vector_len(plan_deg);
		it.func = func;
		it.row = 7'(row);
		it.col = 7'(col);
		it.re = re;
		it.im = im;
		if (func == FUNC_MATRIX) begin
			if (row < m && col < m)
				plan_written[row * DIM + col] = 1'b1;
		end else if (col < m && col == plan_next) begin
			plan_next = (col + 1 >= m) ? 0 : col + 1;
		end
		item_backlog.push_back(it);
		queued_count++;
	endfunction

	// Queues the next element in order, writing any missing entries of its row first.
	function automatic void queue_element(input logic [31:0] re, input logic [31:0] im);
		int c;
		int k;
		c = plan_next;
		for (k = 0; k <= c; k++)
			if (!plan_written[c * DIM + k])
				queue_item(FUNC_MATRIX, c, k, rand_q823(), rand_q823());
		queue_item(FUNC_VECTOR, $urandom_range(127), c, re, im);
	endfunction

	function automatic bit idling_allowed();
		return (cycle_count % 6000) < 4800;
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (item_backlog.size() != 0 || s_tvalid || expected_b.size() != 0);
	endtask

	task automatic set_degree(input int d);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= DEG_W'(d);
		@(posedge clk);
		cfg_wen <= 1'b0;
		deg_now = DEG_W'(d);
		next_col_due = '0;
		plan_deg = DEG_W'(d);
		plan_next = 0;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stream driver: valid stays up until the item is taken.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			compute_b_element(item_on_bus);
		if (!s_tvalid || s_tready) begin
			if (item_backlog.size() != 0 && !(idling_allowed() && $urandom_range(99) < 31)) begin
				item_on_bus = item_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {2'b00, item_on_bus.im, item_on_bus.re, item_on_bus.col,
					item_on_bus.row};
				s_tuser <= item_on_bus.func;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		b_result_t got;
		b_result_t want;
		if (m_tvalid && m_tready) begin
			got.index = m_tdata[6:0];
			got.re = m_tdata[38:7];
			got.im = m_tdata[70:39];
			got.sat = m_tuser[0];
			got.bad = m_tuser[1];
			if (expected_b.size() == 0) begin
				$display("%0t: unexpected result idx=%0d re=%h im=%h sat=%b bad=%b",
					$time, got.index, got.re, got.im, got.sat, got.bad);
				error_count++;
			end else begin
				want = expected_b.pop_front();
				if (got !== want) begin
					$display({"%0t: mismatch expected idx=%0d re=%h im=%h sat=%b bad=%b",
						" actual idx=%0d re=%h im=%h sat=%b bad=%b"}, $time,
						want.index, want.re, want.im, want.sat, want.bad,
						got.index, got.re, got.im, got.sat, got.bad);
					error_count++;
				end
			end
		end
		m_tready <= !(idling_allowed() && $urandom_range(99) < 31);
	end

	initial begin
		int m;
		int d;
		int i;
		int col;
		int phase_len;
		int unsigned pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset degree gives m = 100. Element 0 checks ties rounding upward on both signs.
		queue_item(FUNC_MATRIX, 0, 0, Q_ONE_LSB, '0);
		queue_item(FUNC_VECTOR, 0, 0, Q_HALF_LSB, -Q_HALF_LSB);
		queue_item(FUNC_VECTOR, 0, 5, Q_MAX, Q_MIN);
		queue_item(FUNC_VECTOR, 127, 100, Q_MAX, Q_MAX);
		queue_item(FUNC_VECTOR, 0, 127, Q_MIN, Q_MIN);
		queue_item(FUNC_MATRIX, 100, 0, Q_MAX, Q_MAX);
		queue_item(FUNC_MATRIX, 0, 127, Q_MIN, Q_MIN);
		queue_item(FUNC_MATRIX, 127, 100, Q_MINUS_1, Q_MINUS_1);
		queue_item(FUNC_MATRIX, 0, 99, Q_MAX, Q_MIN);
		queue_item(FUNC_MATRIX, 1, 0, Q_MAX, Q_MAX);
		queue_item(FUNC_MATRIX, 1, 1, Q_MIN, Q_MIN);
		queue_item(FUNC_VECTOR, 99, 1, Q_MIN, Q_MIN);
		queue_item(FUNC_VECTOR, 0, 0, Q_ONE_LSB, Q_ONE_LSB);
		queue_item(FUNC_MATRIX, 2, 0, '0, '0);
		queue_item(FUNC_MATRIX, 2, 1, Q_MINUS_1, Q_MINUS_1);
		queue_item(FUNC_MATRIX, 2, 2, Q_MAX, Q_MIN);
		queue_item(FUNC_VECTOR, 0, 2, Q_MINUS_1, Q_MINUS_1);

		// A single-element vector wraps on every element.
		set_degree(0);
		queue_element(Q_HALF_LSB, Q_MINUS_1);
		queue_element(Q_MIN, Q_MAX);
		queue_item(FUNC_VECTOR, 0, 1, Q_ONE_LSB, Q_ONE_LSB);
		queue_item(FUNC_MATRIX, 1, 0, Q_ONE_LSB, Q_ONE_LSB);
		queue_item(FUNC_MATRIX, 0, 0, Q_MAX, Q_MAX);
		queue_element(Q_MAX, Q_MAX);

		// Degrees above the build maximum clamp; a new degree restarts the order.
		set_degree(15);
		queue_element(rand_q823(), rand_q823());
		queue_element(rand_q823(), rand_q823());
		queue_element(rand_q823(), rand_q823());
		set_degree(12);
		queue_element(rand_q823(), rand_q823());

		// One full vector at a mid-size degree, then the wrap back to element 0.
		set_degree(3);
		m = vector_len(DEG_W'(3));
		for (i = 0; i <= m; i++)
			queue_element(rand_q823(), rand_q823());

		while (queued_count < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 40)
				d = $urandom_range(3);
			else if (pick < 75)
				d = $urandom_range(7, 4);
			else if (pick < 90)
				d = $urandom_range(9, 8);
			else
				d = $urandom_range(15, 10);
			set_degree(d);
			m = vector_len(DEG_W'(d));
			phase_len = $urandom_range(120, 30);
			for (i = 0; i < phase_len && queued_count < ITEM_TARGET; i++) begin
				pick = $urandom_range(99);
				if (pick < 72) begin
					queue_element(rand_q823(), rand_q823());
				end else if (pick < 84) begin
					queue_item(FUNC_MATRIX, $urandom_range(m - 1), $urandom_range(m - 1),
						rand_q823(), rand_q823());
				end else if (pick < 92) begin
					col = $urandom_range(127);
					if (col < m && col == plan_next)
						col = col + 1;
					queue_item(FUNC_VECTOR, $urandom_range(127), col, rand_q823(), rand_q823());
				end else begin
					queue_item(FUNC_MATRIX, $urandom_range(127), $urandom_range(127),
						rand_q823(), rand_q823());
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_b.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_b.size());
			error_count++;
		end
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
